[sv/rpfd_pkg.sv]
// Shared constants, types and command format for the run-length page frame decoder.
package rpfd_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_LINES     = 8;

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + PAGE_LINES - 1) / PAGE_LINES;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int PIXEL_TOTAL = DISPLAY_WIDTH * DISPLAY_HEIGHT;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int BASE_W = $clog2(STORE_BYTES + 1);
    localparam int COL_W  = $clog2(DISPLAY_WIDTH);
    localparam int LINE_W = $clog2(DISPLAY_HEIGHT + 1);
    localparam int IDX_W  = $clog2(PIXEL_TOTAL + 1);
    localparam int BIT_W  = $clog2(PAGE_LINES);
    localparam int LCMP_W = (LINE_W > 6) ? LINE_W : 6;

    localparam int TYPE_W = 2;
    localparam int BYTE_W = 8;
    localparam int PAGE_W = 3;
    localparam int RCOL_W = 7;
    localparam int POS_W  = 14;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [TYPE_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        req_t              op;
        logic [BYTE_W-1:0] count;
        logic              set;
        logic [PAGE_W-1:0] page;
        logic [RCOL_W-1:0] column;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

endpackage

[sv/rle_page_framebuffer_decoder.sv]
// Top level of the run-length page frame decoder.
//
//   channel | signals                                              | direction
//   --------+------------------------------------------------------+----------
//   req     | req_valid, req_ready, req_type, run_count, run_color,| in
//           | read_page, read_column                               |
//   rsp     | rsp_valid, rsp_ready, read_data, pixel_position,     | out
//           | frame_full                                           |
//
// A run word walks its clipped count of pixels: the frame store has one
// read and one write port, and each pixel is a pipelined read-modify-write at one per cycle.
// A read word answers from the read state; frame start and unused words answer from idle.
// Reset needs no clearing pass; bytes not yet reached in the current frame read as zero.
// A two-entry queue takes new words while the executor is busy or its result is stalled.
module rle_page_framebuffer_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [rpfd_pkg::TYPE_W-1:0] req_type,
    input  logic [rpfd_pkg::BYTE_W-1:0] run_count,
    input  logic [rpfd_pkg::BYTE_W-1:0] run_color,
    input  logic [rpfd_pkg::PAGE_W-1:0] read_page,
    input  logic [rpfd_pkg::RCOL_W-1:0] read_column,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [rpfd_pkg::BYTE_W-1:0] read_data,
    output logic [rpfd_pkg::POS_W-1:0]  pixel_position,
    output logic                        frame_full
);
    import rpfd_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_in;
    logic q_pop;
    logic q_valid;
    cmd_t q_out;

    rpfd_front u_front (
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .run_count   (run_count),
        .run_color   (run_color),
        .read_page   (read_page),
        .read_column (read_column),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_in)
    );

    rpfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_out)
    );

    rpfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd            (q_out),
        .cmd_pop        (q_pop),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .read_data      (read_data),
        .pixel_position (pixel_position),
        .frame_full     (frame_full)
    );

endmodule

[sv/rpfd_front.sv]
// Request decoder: accepts words and turns them into queued commands.
module rpfd_front (
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [rpfd_pkg::TYPE_W-1:0] req_type,
    input  logic [rpfd_pkg::BYTE_W-1:0] run_count,
    input  logic [rpfd_pkg::BYTE_W-1:0] run_color,
    input  logic [rpfd_pkg::PAGE_W-1:0] read_page,
    input  logic [rpfd_pkg::RCOL_W-1:0] read_column,
    input  logic                        q_full,
    output logic                        q_push,
    output rpfd_pkg::cmd_t              q_cmd
);
    import rpfd_pkg::*;

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        q_cmd          = '0;
        q_cmd.op       = req_t'(req_type);
        q_cmd.count    = run_count;
        q_cmd.set      = (run_color != '0);
        q_cmd.page     = read_page;
        q_cmd.column   = read_column;
        q_cmd.in_range = (int'(read_page) < PAGE_COUNT) && (int'(read_column) < DISPLAY_WIDTH);
        q_cmd.addr     = ADDR_W'(int'(read_page) * DISPLAY_WIDTH + int'(read_column));
    end

endmodule

[sv/rpfd_queue.sv]
// Small command queue between the decoder and the executor.
module rpfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rpfd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output rpfd_pkg::cmd_t pop_cmd
);
    import rpfd_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/rpfd_back.sv]
// Command executor: frame store, pixel walker and result register.
module rpfd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  rpfd_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [rpfd_pkg::BYTE_W-1:0] read_data,
    output logic [rpfd_pkg::POS_W-1:0]  pixel_position,
    output logic                        frame_full
);
    import rpfd_pkg::*;

    // A byte reads as zero until the walk reaches its top line in the current frame;
    // that first visit overwrites the whole byte, so no clearing pass is needed.

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] bit_mask;

    state_t            state_reg, state_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0]  pix_reg, pix_next;
    logic [BYTE_W-1:0] rem_reg, rem_next;
    logic              set_reg, set_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;
    logic              hit_reg, hit_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [BIT_W-1:0]  pend_bit_reg, pend_bit_next;
    logic              pend_first_reg, pend_first_next;
    logic              pend_set_reg, pend_set_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [BYTE_W-1:0] rsp_data_reg, rsp_data_next;
    logic [POS_W-1:0]  rsp_pos_reg, rsp_pos_next;
    logic              rsp_full_reg, rsp_full_next;

    logic              full;
    logic              slot_free;
    logic              touched;
    logic [LCMP_W-1:0] page_line;

    assign full      = (line_reg == LINE_W'(DISPLAY_HEIGHT));
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign page_line = LCMP_W'(int'(cmd.page) * PAGE_LINES);
    assign touched   = (LCMP_W'(line_reg) > page_line)
                    || ((LCMP_W'(line_reg) == page_line) && (int'(col_reg) > int'(cmd.column)));

    assign bit_mask  = BYTE_W'(1) << pend_bit_reg;
    assign mem_we    = pend_valid_reg;
    assign mem_wdata = (pend_first_reg ? '0 : rd_data_reg) | (pend_set_reg ? bit_mask : '0);

    assign rsp_valid      = rsp_valid_reg;
    assign read_data      = rsp_data_reg;
    assign pixel_position = rsp_pos_reg;
    assign frame_full     = rsp_full_reg;

    always_comb
    begin
        state_next      = state_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        pix_next        = pix_reg;
        rem_next        = rem_reg;
        set_next        = set_reg;
        raddr_next      = raddr_reg;
        hit_next        = hit_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_bit_next   = pend_bit_reg;
        pend_first_next = pend_first_reg;
        pend_set_next   = pend_set_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_full_next   = rsp_full_reg;
        mem_raddr       = raddr_reg;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        REQ_CLEAR:
                        begin
                            line_next      = '0;
                            col_next       = '0;
                            base_next      = '0;
                            pix_next       = '0;
                            rsp_valid_next = 1'b1;
                            rsp_data_next  = '0;
                            rsp_pos_next   = '0;
                            rsp_full_next  = 1'b0;
                        end
                        REQ_RUN:
                        begin
                            rem_next   = cmd.count;
                            set_next   = cmd.set;
                            state_next = ST_WALK;
                        end
                        REQ_READ:
                        begin
                            mem_raddr  = cmd.addr;
                            raddr_next = cmd.addr;
                            hit_next   = cmd.in_range && touched;
                            state_next = ST_READ;
                        end
                        REQ_NONE:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_data_next  = '0;
                            rsp_pos_next   = POS_W'(pix_reg);
                            rsp_full_next  = full;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if ((rem_reg != '0) && !full)
                begin
                    mem_raddr       = ADDR_W'(base_reg + BASE_W'(col_reg));
                    pend_valid_next = 1'b1;
                    pend_addr_next  = ADDR_W'(base_reg + BASE_W'(col_reg));
                    pend_bit_next   = line_reg[BIT_W-1:0];
                    pend_first_next = (line_reg[BIT_W-1:0] == '0);
                    pend_set_next   = set_reg;
                    pix_next        = pix_reg + 1'b1;
                    rem_next        = rem_reg - 1'b1;
                    if (col_reg == COL_W'(DISPLAY_WIDTH - 1))
                    begin
                        col_next  = '0;
                        line_next = line_reg + 1'b1;
                        if (line_reg[BIT_W-1:0] == '1)
                        begin
                            base_next = base_reg + BASE_W'(DISPLAY_WIDTH);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = hit_reg ? rd_data_reg : '0;
                    rsp_pos_next   = POS_W'(pix_reg);
                    rsp_full_next  = full;
                    state_next     = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '0;
                    rsp_pos_next   = POS_W'(pix_reg);
                    rsp_full_next  = full;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_reg       <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            pix_reg        <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            pix_reg        <= pix_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg        <= set_next;
        raddr_reg      <= raddr_next;
        hit_reg        <= hit_next;
        pend_addr_reg  <= pend_addr_next;
        pend_bit_reg   <= pend_bit_next;
        pend_first_reg <= pend_first_next;
        pend_set_reg   <= pend_set_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_pos_reg    <= rsp_pos_next;
        rsp_full_reg   <= rsp_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pend_addr_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

[test/rle_page_framebuffer_decoder_test.sv]
// Testbench for the run-length page frame decoder: directed and random words against a predictor.
`timescale 1ns / 100ps

module rle_page_framebuffer_decoder_test;

    import rpfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned SETTLE_CYCLES = 300;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic              full;
    } pixel_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [TYPE_W-1:0]   req_type = REQ_NONE;
    logic [BYTE_W-1:0]   run_count = '0;
    logic [BYTE_W-1:0]   run_color = '0;
    logic [PAGE_W-1:0]   read_page = '0;
    logic [RCOL_W-1:0]   read_column = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [BYTE_W-1:0]   read_data;
    logic [POS_W-1:0]    pixel_position;
    logic                frame_full;

    logic [BYTE_W-1:0]   shadow_store [STORE_BYTES];
    int unsigned         shadow_pos;
    pixel_result_t       expected_results [$];
    int unsigned         fail_count = 0;
    int unsigned         cycle_count = 0;
    int unsigned         stall_left = 0;
    bit                  idle_on = 1'b1;

    rle_page_framebuffer_decoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .run_count      (run_count),
        .run_color      (run_color),
        .read_page      (read_page),
        .read_column    (read_column),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .read_data      (read_data),
        .pixel_position (pixel_position),
        .frame_full     (frame_full)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic pixel_result_t decode_word(input req_t op,
                                                  input logic [BYTE_W-1:0] count,
                                                  input logic [BYTE_W-1:0] color,
                                                  input logic [PAGE_W-1:0] page,
                                                  input logic [RCOL_W-1:0] column);
        pixel_result_t result;
        int unsigned   span;
        int unsigned   pixel;
        int unsigned   line;
        int unsigned   slot;
        result.data = '0;
        case (op)
            REQ_CLEAR:
            begin
                foreach (shadow_store[a])
                    shadow_store[a] = '0;
                shadow_pos = 0;
            end
            REQ_RUN:
            begin
                span = PIXEL_TOTAL - shadow_pos;
                if (32'(count) < span)
                    span = 32'(count);
                if (color != '0)
                begin
                    for (int unsigned k = 0; k < span; k++)
                    begin
                        pixel = shadow_pos + k;
                        line = pixel / DISPLAY_WIDTH;
                        slot = (line / PAGE_LINES) * DISPLAY_WIDTH + pixel % DISPLAY_WIDTH;
                        if (slot < STORE_BYTES)
                            shadow_store[slot] = shadow_store[slot]
                                                 | (8'h01 << (line % PAGE_LINES));
                    end
                end
                shadow_pos = shadow_pos + span;
            end
            REQ_READ:
            begin
                if (int'(page) < PAGE_COUNT && int'(column) < DISPLAY_WIDTH)
                    result.data = shadow_store[int'(page) * DISPLAY_WIDTH + int'(column)];
            end
            default:
            begin
            end
        endcase
        result.position = shadow_pos[POS_W-1:0];
        result.full = (shadow_pos >= PIXEL_TOTAL);
        return result;
    endfunction

    task automatic note_failure(input string what);
        if (fail_count < REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        pixel_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_results.size() == 0)
            begin
                note_failure($sformatf("unexpected word data=%02h pos=%0d full=%0d",
                                       read_data, pixel_position, frame_full));
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.data || pixel_position !== want.position
                    || frame_full !== want.full)
                    note_failure($sformatf(
                        "expected data=%02h pos=%0d full=%0d, got data=%02h pos=%0d full=%0d",
                        want.data, want.position, want.full,
                        read_data, pixel_position, frame_full));
            end
        end
    end

    task automatic send_word(input req_t op,
                             input logic [BYTE_W-1:0] count,
                             input logic [BYTE_W-1:0] color,
                             input logic [PAGE_W-1:0] page,
                             input logic [RCOL_W-1:0] column);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= op;
        run_count <= count;
        run_color <= color;
        read_page <= page;
        read_column <= column;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_results.push_back(decode_word(op, count, color, page, column));
    endtask

    task automatic wait_results_drained();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd7, 7'd127);
        send_word(REQ_NONE, 8'd255, 8'd255, 3'd7, 7'd127);
        send_word(REQ_RUN, 8'd0, 8'd0, 3'd0, 7'd0);
    endtask

    task automatic test_runs_and_reads();
        send_word(REQ_CLEAR, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_RUN, 8'd0, 8'hFF, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_RUN, 8'd255, 8'h01, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd127);
        send_word(REQ_RUN, 8'd1, 8'h80, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd127);
        send_word(REQ_RUN, 8'd255, 8'h00, 3'd0, 7'd0);
        send_word(REQ_RUN, 8'd3, 8'hFF, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd126);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd7, 7'd0);
        send_word(REQ_NONE, 8'd17, 8'd33, 3'd5, 7'd99);
    endtask

    task automatic test_frame_end();
        send_word(REQ_CLEAR, 8'd255, 8'd255, 3'd7, 7'd127);
        for (int k = 0; k < 32; k++)
            send_word(REQ_RUN, 8'd255, (k % 2 == 0) ? 8'hFF : 8'h00, 3'd0, 7'd0);
        send_word(REQ_RUN, 8'd255, 8'h5A, 3'd0, 7'd0);
        send_word(REQ_RUN, 8'd255, 8'hFF, 3'd0, 7'd0);
        send_word(REQ_RUN, 8'd0, 8'hFF, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd7, 7'd127);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd3, 7'd64);
        send_word(REQ_NONE, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_CLEAR, 8'd0, 8'd0, 3'd0, 7'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 3'd7, 7'd127);
    endtask

    task automatic test_random_frames(input int unsigned word_goal, input bit with_idling);
        int unsigned       pick;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] color;
        idle_on = with_idling;
        for (int unsigned n = 0; n < word_goal; n++)
        begin
            pick = $urandom_range(0, 199);
            case ($urandom_range(0, 9))
                0: count = 8'd0;
                1: count = 8'd255;
                default: count = 8'($urandom_range(0, 255));
            endcase
            color = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if (pick == 0 || (shadow_pos >= PIXEL_TOTAL && pick < 60))
                send_word(REQ_CLEAR, count, color, 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)));
            else if (pick < 3)
                send_word(REQ_NONE, count, color, 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)));
            else if (pick < 48)
                send_word(REQ_READ, count, color, 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)));
            else
                send_word(REQ_RUN, count, color, 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)));
        end
    endtask

    initial
    begin
        foreach (shadow_store[a])
            shadow_store[a] = '0;
        shadow_pos = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_runs_and_reads();
        test_frame_end();
        test_random_frames(800, 1'b1);
        test_random_frames(300, 1'b0);
        wait_results_drained();
        test_random_frames(700, 1'b1);
        test_random_frames(200, 1'b0);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
